// ===== sv/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants shared by the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam logic [4:0] METRIC_INF = 5'd16;
  localparam logic [7:0] EXPIRE_RESET = 8'd30;
  localparam logic [7:0] HOLDDOWN_RESET = 8'd15;
  localparam logic [7:0] UPDATE_RESET = 8'd15;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_LOCAL  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_ADV    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_MODIFY = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_ADV    = 3'd4,
    ACT_FULL   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    REG_EXPIRE   = 2'd0,
    REG_HOLDDOWN = 2'd1,
    REG_UPDATE   = 2'd2
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] dst_addr;
    logic [31:0] net_mask;
    logic [15:0] metric_in;
    logic [31:0] neighbour_addr;
    logic [1:0]  iface;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] route_dst;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [4:0]  route_metric;
    logic        route_invalid;
    logic        update_due;
    logic        last_item;
  } out_item_t;

  // One table entry
  typedef struct packed {
    logic        used;
    logic [31:0] dst;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [4:0]  metric;
    logic        invalid;
    logic        learned;
    logic [1:0]  port;
    logic [31:0] expire_at;
    logic [31:0] purge_at;
  } entry_t;

  // Deadline reached test with wrap-around
  function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

endpackage

// ===== sv/dvrt_cell.sv =====
// ----------------------------------------------------------------------------
// dvrt_cell
// One table slot. In a walk cycle the slot takes the entry of its upper
// neighbour (or the rewritten entry at the head), so the table rotates by one.
// ----------------------------------------------------------------------------
module dvrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  dvrt_pkg::entry_t  entry_in,
  output dvrt_pkg::entry_t  entry
);
  import dvrt_pkg::*;

  logic   used;
  entry_t held;

  // used bit is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (shift) begin
      used <= entry_in.used;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= entry_in;
    end
  end

  always_comb begin
    entry      = held;
    entry.used = used;
  end

endmodule

// ===== sv/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// RIP-style route table held in a rotating chain of slot cells.
// ----------------------------------------------------------------------------
// Every command walks the table: the chain of TABLE_DEPTH cells rotates
// one slot per cycle, slot 0 passing the head. A tick or advertise walks
// it once. An update or local insert needs two walks, one to look up the
// destination and free slot and one to write; an update whose port is out
// of range walks once.
// Results appear with a one-cycle strobe (result_valid) and cannot be
// stalled; busy is high for the whole walk, and the last result of a command
// is on the ports in the first cycle after busy falls. No clearing pass after
// reset.
module distance_vector_route_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int PORT_COUNT  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dvrt_pkg::in_item_t  item,
  output logic                result_valid,
  output dvrt_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import dvrt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  // configuration
  logic [7:0] expire_seconds, holddown_seconds, update_seconds;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      expire_seconds   <= EXPIRE_RESET;
      holddown_seconds <= HOLDDOWN_RESET;
      update_seconds   <= UPDATE_RESET;
    end else if (cfg_valid) begin
      unique case (reg_t'(cfg_index))
        REG_EXPIRE:   expire_seconds   <= cfg_data;
        REG_HOLDDOWN: holddown_seconds <= cfg_data;
        REG_UPDATE:   update_seconds   <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell chain
  entry_t cells [TABLE_DEPTH];
  entry_t head_in;
  logic   shift;
  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == TABLE_DEPTH - 1) begin : g_top
        dvrt_cell u_cell (.clk, .rst, .shift, .entry_in(head_in), .entry(cells[g]));
      end else begin : g_mid
        dvrt_cell u_cell (.clk, .rst, .shift, .entry_in(cells[g+1]), .entry(cells[g]));
      end
    end
  endgenerate
  entry_t head;
  assign head = cells[0];

  // control
  state_t state, state_next;
  in_item_t cmd;
  logic [IW-1:0] pos;           // slot index of head
  logic pass;                   // 0 lookup walk, 1 write walk
  logic [31:0] seconds_now, next_update_at;
  logic due;
  logic tick_due;
  logic found, free_ok;
  logic [IW-1:0] found_pos, free_pos;
  logic [4:0] met;
  logic last_slot;

  assign last_slot = (pos == IW'(TABLE_DEPTH - 1));
  assign met = (cmd.metric_in >= 16'd15) ? METRIC_INF : 5'(cmd.metric_in + 16'd1);
  assign busy = (state != ST_IDLE);
  assign tick_due = (item.command == CMD_TICK) &&
                    reached(seconds_now + 32'd1, next_update_at);

  // per-slot decision at the head
  entry_t rewrite;
  logic emit;
  out_item_t res;
  logic port_ok;
  assign port_ok = ({30'd0, cmd.iface} < 32'(PORT_COUNT));

  always_comb begin
    rewrite = head;
    emit = 1'b0;
    res = '0;
    res.route_dst = head.dst;
    res.route_mask = head.mask;
    res.route_gateway = head.gateway;
    res.route_metric = head.metric;
    res.route_invalid = head.invalid;
    if (state == ST_SCAN) begin
      unique case (cmd_t'(cmd.command))
        CMD_TICK: begin
          if (head.used && head.learned) begin
            if (!head.invalid) begin
              if (reached(seconds_now, head.expire_at)) begin
                rewrite.invalid = 1'b1;
                rewrite.metric = METRIC_INF;
                emit = 1'b1;
                res.action = ACT_MODIFY;
                res.route_metric = METRIC_INF;
                res.route_invalid = 1'b1;
              end
            end else if (reached(seconds_now, head.purge_at)) begin
              rewrite.used = 1'b0;
              emit = 1'b1;
              res.action = ACT_DELETE;
            end
          end
        end
        CMD_ADV: begin
          if (port_ok && head.used && !(head.learned && head.port == cmd.iface)) begin
            emit = 1'b1;
            res.action = ACT_ADV;
          end
        end
        CMD_UPDATE: begin
          if (pass && found && pos == found_pos) begin
            // local and invalid entries are left untouched
            if (head.learned && !head.invalid) begin
              if (met < head.metric ||
                  (cmd.neighbour_addr == head.gateway && met != head.metric)) begin
                rewrite.mask = cmd.net_mask;
                rewrite.gateway = cmd.neighbour_addr;
                rewrite.metric = met;
                rewrite.port = cmd.iface;
                if (met != METRIC_INF) begin
                  rewrite.invalid = 1'b0;
                  rewrite.expire_at = seconds_now + 32'(expire_seconds);
                  rewrite.purge_at = seconds_now + 32'(expire_seconds) +
                                     32'(holddown_seconds);
                end else begin
                  rewrite.invalid = 1'b1;
                end
                emit = 1'b1;
                res.action = ACT_MODIFY;
                res.route_dst = head.dst;
                res.route_mask = cmd.net_mask;
                res.route_gateway = cmd.neighbour_addr;
                res.route_metric = met;
                res.route_invalid = (met == METRIC_INF);
              end else if (cmd.neighbour_addr == head.gateway) begin
                rewrite.expire_at = seconds_now + 32'(expire_seconds);
                rewrite.purge_at = seconds_now + 32'(expire_seconds) +
                                   32'(update_seconds);
              end
            end
          end else if (pass && !found && free_ok && met != METRIC_INF &&
                       pos == free_pos) begin
            rewrite.used = 1'b1;
            rewrite.dst = cmd.dst_addr;
            rewrite.mask = cmd.net_mask;
            rewrite.gateway = cmd.neighbour_addr;
            rewrite.metric = met;
            rewrite.invalid = 1'b0;
            rewrite.learned = 1'b1;
            rewrite.port = cmd.iface;
            rewrite.expire_at = seconds_now + 32'(expire_seconds);
            rewrite.purge_at = seconds_now + 32'(expire_seconds) + 32'(holddown_seconds);
            emit = 1'b1;
            res.action = ACT_ADD;
            res.route_dst = cmd.dst_addr;
            res.route_mask = cmd.net_mask;
            res.route_gateway = cmd.neighbour_addr;
            res.route_metric = met;
            res.route_invalid = 1'b0;
          end
        end
        CMD_LOCAL: begin
          if (pass && free_ok && pos == free_pos) begin
            rewrite = '0;
            rewrite.used = 1'b1;
            rewrite.dst = cmd.dst_addr;
            rewrite.mask = cmd.net_mask;
            emit = 1'b1;
            res.action = ACT_ADD;
            res.route_dst = cmd.dst_addr;
            res.route_mask = cmd.net_mask;
            res.route_gateway = '0;
            res.route_metric = '0;
            res.route_invalid = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
  assign head_in = rewrite;
  assign shift = (state == ST_SCAN);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN: begin
        if (last_slot) begin
          if ((cmd.command == CMD_UPDATE || cmd.command == CMD_LOCAL) && !pass &&
              (cmd.command == CMD_LOCAL || port_ok))
            state_next = ST_SCAN;
          else
            state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // walk bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      pass <= 1'b0;
      seconds_now <= '0;
      next_update_at <= 32'(UPDATE_RESET);
      due <= 1'b0;
      found <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (start) begin
          cmd <= item;
          pos <= '0;
          pass <= 1'b0;
          found <= 1'b0;
          free_ok <= 1'b0;
          due <= tick_due;
          if (item.command == CMD_TICK) seconds_now <= seconds_now + 32'd1;
          if (tick_due) next_update_at <= seconds_now + 32'd1 + 32'(update_seconds);
        end
        ST_SCAN: begin
          pos <= last_slot ? '0 : pos + IW'(1);
          if (last_slot) pass <= 1'b1;
          if (!pass && head.used && head.dst == cmd.dst_addr && !found) begin
            found <= 1'b1;
            found_pos <= pos;
          end
          if (!pass && !head.used && !free_ok) begin
            free_ok <= 1'b1;
            free_pos <= pos;
          end
        end
        default: ;
      endcase
    end
  end

  // result when the walk emitted nothing
  out_item_t final_res;
  always_comb begin
    final_res = '0;
    if (cmd.command == CMD_UPDATE && port_ok && !found && met != METRIC_INF && !free_ok) begin
      final_res.action = ACT_FULL;
      final_res.route_dst = cmd.dst_addr;
      final_res.route_mask = cmd.net_mask;
      final_res.route_gateway = cmd.neighbour_addr;
      final_res.route_metric = met;
    end else if (cmd.command == CMD_LOCAL && !free_ok) begin
      final_res.action = ACT_FULL;
      final_res.route_dst = cmd.dst_addr;
      final_res.route_mask = cmd.net_mask;
    end
  end

  // result staging: hold one pending result so last_item can be marked
  out_item_t pend;
  logic pend_valid;
  logic out_fire;
  out_item_t out_next;

  always_comb begin
    out_fire = 1'b0;
    out_next = pend;
    if (state == ST_SCAN && emit && pend_valid) begin
      out_fire = 1'b1;
    end else if (state == ST_FINISH) begin
      out_fire = 1'b1;
      if (!pend_valid) out_next = final_res;
      out_next.last_item = 1'b1;
      out_next.update_due = due;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_fire;
      if (state == ST_IDLE) pend_valid <= 1'b0;
      else if (state == ST_SCAN && emit) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) result <= out_next;
    if (state == ST_SCAN && emit) pend <= res;
  end

  // assertions
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_item |=> !result_valid) else $error("strobe after last");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_finish_gives_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> result_valid && result.last_item) else $error("no last");

endmodule

// ===== tb/tb_distance_vector_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table
// Self-checking testbench for the RIP-style route table: a directed opening
// run, then random command traffic checked against a route table predictor.
// ----------------------------------------------------------------------------

// Scoreboard: predicts the result run of each accepted command and checks
// each result strobe against the oldest prediction.
class route_scoreboard;
  localparam int DEPTH = 32;
  localparam int PORTS = 4;

  // Predicted table and timers
  bit          used[DEPTH];
  bit [31:0]   dst[DEPTH];
  bit [31:0]   mask[DEPTH];
  bit [31:0]   gw[DEPTH];
  bit [4:0]    metric[DEPTH];
  bit          invalid[DEPTH];
  bit          learned[DEPTH];
  bit [1:0]    port[DEPTH];
  bit [31:0]   expire_at[DEPTH];
  bit [31:0]   purge_at[DEPTH];
  bit [31:0]   now;
  bit [31:0]   next_update;
  bit [7:0]    expire_s;
  bit [7:0]    holddown_s;
  bit [7:0]    update_s;

  dvrt_pkg::out_item_t pending_routes[$];
  int mismatches;

  function void init();
    for (int i = 0; i < DEPTH; i++) used[i] = 0;
    now = 0;
    expire_s = dvrt_pkg::EXPIRE_RESET;
    holddown_s = dvrt_pkg::HOLDDOWN_RESET;
    update_s = dvrt_pkg::UPDATE_RESET;
    next_update = 32'(update_s);
    mismatches = 0;
  endfunction

  function void set_reg(dvrt_pkg::reg_t idx, bit [7:0] v);
    case (idx)
      dvrt_pkg::REG_EXPIRE:   expire_s = v;
      dvrt_pkg::REG_HOLDDOWN: holddown_s = v;
      default:                update_s = v;
    endcase
  endfunction

  function bit due(bit [31:0] deadline);
    bit [31:0] d;
    d = now - deadline;
    return ~d[31];
  endfunction

  function dvrt_pkg::out_item_t mk(dvrt_pkg::act_t a, bit [31:0] d, bit [31:0] m,
                                   bit [31:0] g, bit [4:0] met, bit inv);
    dvrt_pkg::out_item_t r;
    r = '0;
    r.action = a;
    r.route_dst = d;
    r.route_mask = m;
    r.route_gateway = g;
    r.route_metric = met;
    r.route_invalid = inv;
    return r;
  endfunction

  function dvrt_pkg::out_item_t from_slot(dvrt_pkg::act_t a, int i);
    return mk(a, dst[i], mask[i], gw[i], metric[i], invalid[i]);
  endfunction

  function int free_slot();
    for (int i = 0; i < DEPTH; i++) if (!used[i]) return i;
    return -1;
  endfunction

  // Note an accepted command and queue its predicted results
  function void note_command(dvrt_pkg::in_item_t it);
    dvrt_pkg::out_item_t run[$];
    dvrt_pkg::out_item_t r;
    bit [4:0] met;
    bit [31:0] tgw;
    int f;
    bit upd;
    f = -1;
    upd = 0;
    case (dvrt_pkg::cmd_t'(it.command))
      dvrt_pkg::CMD_UPDATE: begin
        tgw = it.neighbour_addr;
        met = (it.metric_in >= 16'd15) ? dvrt_pkg::METRIC_INF : 5'(it.metric_in + 1);
        for (int i = 0; i < DEPTH; i++)
          if (f < 0 && used[i] && dst[i] == it.dst_addr) f = i;
        if (int'(it.iface) >= PORTS) begin
          run.push_back('0);
        end else if (f >= 0) begin
          if (!learned[f] || invalid[f]) begin
            run.push_back('0);
          end else if (met < metric[f] || (tgw == gw[f] && met != metric[f])) begin
            mask[f] = it.net_mask;
            gw[f] = tgw;
            metric[f] = met;
            port[f] = it.iface;
            if (met != dvrt_pkg::METRIC_INF) begin
              invalid[f] = 0;
              expire_at[f] = now + expire_s;
              purge_at[f] = now + expire_s + holddown_s;
            end else begin
              invalid[f] = 1;
            end
            run.push_back(from_slot(dvrt_pkg::ACT_MODIFY, f));
          end else begin
            // Refresh only
            if (tgw == gw[f]) begin
              expire_at[f] = now + expire_s;
              purge_at[f] = now + expire_s + update_s;
            end
            run.push_back('0);
          end
        end else if (met == dvrt_pkg::METRIC_INF) begin
          run.push_back('0);
        end else begin
          f = free_slot();
          if (f < 0) begin
            run.push_back(mk(dvrt_pkg::ACT_FULL, it.dst_addr, it.net_mask, tgw, met, 0));
          end else begin
            used[f] = 1; dst[f] = it.dst_addr; mask[f] = it.net_mask; gw[f] = tgw;
            metric[f] = met; invalid[f] = 0; learned[f] = 1; port[f] = it.iface;
            expire_at[f] = now + expire_s;
            purge_at[f] = now + expire_s + holddown_s;
            run.push_back(from_slot(dvrt_pkg::ACT_ADD, f));
          end
        end
      end
      dvrt_pkg::CMD_LOCAL: begin
        f = free_slot();
        if (f < 0) begin
          run.push_back(mk(dvrt_pkg::ACT_FULL, it.dst_addr, it.net_mask, 0, 0, 0));
        end else begin
          used[f] = 1; dst[f] = it.dst_addr; mask[f] = it.net_mask; gw[f] = 0;
          metric[f] = 0; invalid[f] = 0; learned[f] = 0; port[f] = 0;
          expire_at[f] = 0; purge_at[f] = 0;
          run.push_back(from_slot(dvrt_pkg::ACT_ADD, f));
        end
      end
      dvrt_pkg::CMD_TICK: begin
        now = now + 1;
        if (due(next_update)) begin
          upd = 1;
          next_update = now + update_s;
        end
        for (int i = 0; i < DEPTH; i++) begin
          if (used[i] && learned[i]) begin
            if (!invalid[i]) begin
              if (due(expire_at[i])) begin
                invalid[i] = 1;
                metric[i] = dvrt_pkg::METRIC_INF;
                run.push_back(from_slot(dvrt_pkg::ACT_MODIFY, i));
              end
            end else if (due(purge_at[i])) begin
              run.push_back(from_slot(dvrt_pkg::ACT_DELETE, i));
              used[i] = 0;
            end
          end
        end
        if (run.size() == 0) run.push_back('0);
        run[run.size()-1].update_due = upd;
      end
      default: begin
        if (int'(it.iface) < PORTS)
          for (int i = 0; i < DEPTH; i++)
            if (used[i] && !(learned[i] && port[i] == it.iface))
              run.push_back(from_slot(dvrt_pkg::ACT_ADV, i));
        if (run.size() == 0) run.push_back('0);
      end
    endcase
    run[run.size()-1].last_item = 1;
    foreach (run[k]) pending_routes.push_back(run[k]);
  endfunction

  // Check one result strobe
  function void check_route(dvrt_pkg::out_item_t got);
    dvrt_pkg::out_item_t exp_r;
    if (pending_routes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_routes.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("mismatch: act %0d/%0d dst %h/%h mask %h/%h gw %h/%h",
               exp_r.action, got.action, exp_r.route_dst, got.route_dst,
               exp_r.route_mask, got.route_mask, exp_r.route_gateway, got.route_gateway);
        $display(" met %0d/%0d inv %b/%b due %b/%b last %b/%b",
                 exp_r.route_metric, got.route_metric, exp_r.route_invalid,
                 got.route_invalid, exp_r.update_due, got.update_due,
                 exp_r.last_item, got.last_item);
      end
    end
  endfunction
endclass

module tb_distance_vector_route_table;
  import dvrt_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      result_valid;
  out_item_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  route_scoreboard sb;
  int cycles;
  bit [31:0] dst_pool[8];

  distance_vector_route_table u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) sb.check_route(result);
    if (cycles > LIMIT) begin
      $display("distance_vector_route_table test failed");
      $finish;
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // Issue one command; waits for the accepting edge. start stays high after
  // acceptance until the next gap or drain lowers it.
  task automatic send_command(in_item_t it);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      idle_cycles(gap);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_command(it);
  endtask

  // Wait until all predicted results are in, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_routes.size() != 0) @(posedge clk);
    idle_cycles(80);
  endtask

  task automatic write_reg(reg_t idx, bit [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t mk_cmd(cmd_t c, bit [31:0] d, bit [31:0] m,
                                      bit [15:0] met, bit [31:0] g, bit [1:0] ifc);
    in_item_t it;
    it.command = c; it.dst_addr = d; it.net_mask = m;
    it.metric_in = met; it.neighbour_addr = g; it.iface = ifc;
    return it;
  endfunction

  function automatic in_item_t rand_cmd();
    int r;
    r = $urandom_range(0, 99);
    return mk_cmd(r < 45 ? CMD_UPDATE : r < 55 ? CMD_LOCAL : r < 85 ? CMD_TICK : CMD_ADV,
                  ($urandom_range(0, 9) == 0) ? $urandom() : dst_pool[$urandom_range(0, 7)],
                  $urandom(),
                  ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 16)),
                  ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 3)),
                  2'($urandom()));
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) send_command(rand_cmd());
    drain();
  endtask

  initial begin
    sb = new();
    sb.init();
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_EXPIRE;
    cfg_data = '0;
    for (int i = 0; i < 8; i++) dst_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command and the listed corner cases
    send_command(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    send_command(mk_cmd(CMD_ADV, 0, 0, 0, 0, 0));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                        32'hFFFF_FFFF, 2'd3));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 0, 32'hFFFF_FFFF, 2'd3));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 0, 32'hFFFF_FFFF, 2'd3));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 16'd4, 32'd7, 2'd1));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 16'd2, 32'hFFFF_FFFF, 2'd2));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 16'd15, 32'hFFFF_FFFF, 2'd2));
    send_command(mk_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 0, 0, 32'd5, 2'd0));
    send_command(mk_cmd(CMD_LOCAL, 32'h0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 2'd3));
    send_command(mk_cmd(CMD_LOCAL, 32'h0, 32'hFFFF_FFFF, 0, 0, 0));
    send_command(mk_cmd(CMD_UPDATE, 32'h0, 0, 0, 32'd9, 2'd0));
    send_command(mk_cmd(CMD_UPDATE, 32'h0A00_0000, 32'hFF00_0000, 16'd14, 32'd1, 2'd0));
    for (int p = 0; p < 4; p++) send_command(mk_cmd(CMD_ADV, 0, 0, 0, 0, 2'(p)));
    drain();

    // Short timers so routes expire and purge quickly
    write_reg(REG_EXPIRE, 8'd1);
    write_reg(REG_HOLDDOWN, 8'd1);
    write_reg(REG_UPDATE, 8'd1);
    for (int k = 0; k < 4; k++) send_command(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    drain();

    // Fill the table to overflow
    for (int k = 0; k < 34; k++)
      send_command(mk_cmd(CMD_LOCAL, $urandom(), $urandom(), 0, 0, 0));
    send_command(mk_cmd(CMD_UPDATE, 32'h0102_0304, $urandom(), 16'd3, 32'd2, 2'd1));
    drain();

    // Reset clears the table only once, so run random traffic on the full table
    // under changing timers: locals stay, learned routes churn
    write_reg(REG_EXPIRE, 8'd3);
    write_reg(REG_HOLDDOWN, 8'd2);
    write_reg(REG_UPDATE, 8'd4);
    random_phase(45);
    write_reg(REG_EXPIRE, 8'd255);
    write_reg(REG_HOLDDOWN, 8'd255);
    write_reg(REG_UPDATE, 8'd255);
    random_phase(45);
    write_reg(REG_EXPIRE, 8'd5);
    write_reg(REG_HOLDDOWN, 8'd3);
    write_reg(REG_UPDATE, 8'd7);
    random_phase(60);
    write_reg(REG_EXPIRE, 8'd30);
    write_reg(REG_HOLDDOWN, 8'd15);
    write_reg(REG_UPDATE, 8'd15);
    random_phase(55);

    if (sb.mismatches == 0 && sb.pending_routes.size() == 0)
      $display("distance_vector_route_table test passed");
    else
      $display("distance_vector_route_table test failed");
    $finish;
  end
endmodule
